// ----- rtl/brr_adpcm_sample_decoder_core_assert.svh -----
// ----------------------------------------------------------------------------
// BRR ADPCM decoder assertion macros
// Concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BRR_ADPCM_SAMPLE_DECODER_CORE_ASSERT_SVH
`define BRR_ADPCM_SAMPLE_DECODER_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define BRR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("brr assertion failed");
// next-cycle implication
`define BRR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("brr assertion failed");
`else
`define BRR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BRR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/brr_pkg.sv -----
// ----------------------------------------------------------------------------
// BRR ADPCM decoder package
// Shared widths, types and constants for the sample decoder.
// ----------------------------------------------------------------------------
package brr_pkg;

    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 16;
    localparam int NIB_W    = 4;
    localparam int RANGE_W  = 4;

    typedef logic [BYTE_W-1:0]          t_byte;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // prediction filter selected by header bits 3..2
    typedef enum logic [1:0] {
        FILT_NONE  = 2'd0,
        FILT_ONE   = 2'd1,
        FILT_TWO   = 2'd2,
        FILT_THREE = 2'd3
    } t_filter;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = -16'sh8000;
    localparam t_sample BIG_RANGE_NEG = ~16'sh07FF;  // -2048
    localparam logic [RANGE_W-1:0] RANGE_MAX = 4'd12;

    // header byte layout
    localparam int HDR_END_BIT  = 0;
    localparam int HDR_LOOP_BIT = 1;
    localparam int HDR_FILT_LSB = 2;
    localparam int HDR_RANGE_LSB = 4;

endpackage

// ----- rtl/brr_stream_ifs.sv -----
// ----------------------------------------------------------------------------
// BRR ADPCM decoder stream interfaces
// Valid/ready channels for data bytes in and PCM samples out.
// ----------------------------------------------------------------------------
interface brr_byte_if import brr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte header_byte;
    t_byte data_byte;
    logic  clear_history;

    modport source (output valid, header_byte, data_byte, clear_history, input ready);
    modport sink   (input valid, header_byte, data_byte, clear_history, output ready);
endinterface

interface brr_sample_if import brr_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample;
    logic    second_of_pair;
    logic    block_end;
    logic    block_loop;

    modport source (output valid, sample, second_of_pair, block_end, block_loop,
                    input ready);
    modport sink   (input valid, sample, second_of_pair, block_end, block_loop,
                    output ready);
endinterface

// ----- rtl/brr_adpcm_sample_decoder_core.sv -----
// ----------------------------------------------------------------------------
// BRR ADPCM sample decoder core
// Turns one header/data byte pair into two 16-bit PCM samples.
// ----------------------------------------------------------------------------
// Each accepted transaction on i_in carries a block header byte, one data
// byte and a key-on flag (clear_history). It yields two transactions on
// o_out: the high nibble's sample (second_of_pair = 0), then the low
// nibble's (second_of_pair = 1), both tagged with the header's end and loop
// bits. The single nibble decode stage makes one sample per cycle while the
// output register is not stalled and feeds the next one from the history
// it just wrote. A byte waits in the input holding stage and its samples
// leave through the output register. A new byte is taken in the cycle its
// predecessor's low nibble moves to the output register. Decoding stalls
// while a finished sample waits in the output register, so i_in.ready
// follows o_out.ready combinationally while the stage holds a low nibble.
// No clearing pass after reset: both history registers reset to zero.
`include "brr_adpcm_sample_decoder_core_assert.svh"

module brr_adpcm_sample_decoder_core
    import brr_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    brr_byte_if.sink     i_in,
    brr_sample_if.source o_out
);

    localparam int SUM_W = SAMPLE_W + 4;  // holds 13*a and all prediction sums
    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(SAMPLE_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(SAMPLE_MIN);

    // input holding stage
    logic    r_a_valid, n_a_valid;
    logic    r_phase,   n_phase;     // 0: high nibble next, 1: low nibble next
    t_byte   r_hdr,     n_hdr;
    t_byte   r_dat,     n_dat;
    logic    r_clr,     n_clr;

    // prediction history
    t_sample r_prev1, n_prev1;
    t_sample r_prev2, n_prev2;

    // output register
    logic    r_out_valid,  n_out_valid;
    t_sample r_out_sample, n_out_sample;
    logic    r_out_second, n_out_second;
    logic    r_out_end,    n_out_end;
    logic    r_out_loop,   n_out_loop;

    logic    load, in_fire, clr_now;
    t_sample hist_a, hist_b;
    logic [NIB_W-1:0]   nib;
    logic [RANGE_W-1:0] range_q;
    t_filter            filt;

    t_sample                 s16, shl, scaled;
    logic signed [SUM_W-1:0] a20, b20, neg_a, neg_b, a_half, b_half;
    logic signed [SUM_W-1:0] a13, a15, b15, pred, sum;
    t_sample                 clamped, doubled;

    // --- handshake ---
    assign load       = r_a_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_a_valid || (r_phase && load);
    assign in_fire    = i_in.valid && i_in.ready;

    // --- nibble decode ---
    assign clr_now = r_clr && !r_phase;   // key-on applies before the first nibble
    assign hist_a  = clr_now ? '0 : r_prev1;
    assign hist_b  = clr_now ? '0 : r_prev2;
    assign nib     = r_phase ? r_dat[NIB_W-1:0] : r_dat[BYTE_W-1:NIB_W];
    assign range_q = r_hdr[HDR_RANGE_LSB +: RANGE_W];
    assign filt    = t_filter'(r_hdr[HDR_FILT_LSB +: 2]);

    always_comb begin
        s16 = {{(SAMPLE_W-NIB_W){nib[NIB_W-1]}}, nib};
        shl = s16 <<< range_q;          // -8 << 12 still fits 16 bits
        if (range_q <= RANGE_MAX) begin
            scaled = shl >>> 1;
        end else begin
            scaled = nib[NIB_W-1] ? BIG_RANGE_NEG : '0;
        end
    end

    always_comb begin
        a20    = SUM_W'(hist_a);
        b20    = SUM_W'(hist_b);
        neg_a  = -a20;
        neg_b  = -b20;
        a_half = a20 >>> 1;
        b_half = b20 >>> 1;
        a13    = (a20 <<< 3) + (a20 <<< 2) + a20;
        a15    = a20 + a_half;
        b15    = b20 + b_half;
        case (filt)
            FILT_NONE:  pred = '0;
            FILT_ONE:   pred = a_half + (neg_a >>> 5);
            FILT_TWO:   pred = a20 + ((-a15) >>> 5) + (neg_b >>> 1) + (b20 >>> 5);
            FILT_THREE: pred = a20 + ((-a13) >>> 7) + (neg_b >>> 1) + (b15 >>> 4);
            default:    pred = '0;
        endcase
        sum = SUM_W'(scaled) + pred;
        if (filt == FILT_NONE) begin
            clamped = sum[SAMPLE_W-1:0];
        end else if (sum > SUM_MAX) begin
            clamped = SAMPLE_MAX;
        end else if (sum < SUM_MIN) begin
            clamped = SAMPLE_MIN;
        end else begin
            clamped = sum[SAMPLE_W-1:0];
        end
        doubled = {clamped[SAMPLE_W-2:0], 1'b0};   // x2 with 16-bit wrap
    end

    // --- next state ---
    always_comb begin
        n_a_valid    = r_a_valid;
        n_phase      = r_phase;
        n_hdr        = r_hdr;
        n_dat        = r_dat;
        n_clr        = r_clr;
        n_prev1      = r_prev1;
        n_prev2      = r_prev2;
        n_out_valid  = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_second = r_out_second;
        n_out_end    = r_out_end;
        n_out_loop   = r_out_loop;

        if (in_fire) begin
            n_a_valid = 1'b1;
            n_phase   = 1'b0;
            n_hdr     = i_in.header_byte;
            n_dat     = i_in.data_byte;
            n_clr     = i_in.clear_history;
        end else if (load && r_phase) begin
            n_a_valid = 1'b0;
        end else if (load) begin
            n_phase = 1'b1;
        end

        if (load) begin
            n_prev2      = hist_a;
            n_prev1      = doubled;
            n_out_valid  = 1'b1;
            n_out_sample = doubled;
            n_out_second = r_phase;
            n_out_end    = r_hdr[HDR_END_BIT];
            n_out_loop   = r_hdr[HDR_LOOP_BIT];
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev1     <= '0;
            r_prev2     <= '0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_prev1     <= n_prev1;
            r_prev2     <= n_prev2;
        end
        r_hdr        <= n_hdr;
        r_dat        <= n_dat;
        r_clr        <= n_clr;
        r_out_sample <= n_out_sample;
        r_out_second <= n_out_second;
        r_out_end    <= n_out_end;
        r_out_loop   <= n_out_loop;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.sample         = r_out_sample;
    assign o_out.second_of_pair = r_out_second;
    assign o_out.block_end      = r_out_end;
    assign o_out.block_loop     = r_out_loop;

    // --- checks ---
    // a new byte only overwrites the stage as its low nibble leaves
    `BRR_ASSERT_IMP(a_in_only_on_last, i_clk, i_rst_n, in_fire && r_a_valid, r_phase && load)
    // the low nibble's sample is the one marked second
    `BRR_ASSERT_NXT(a_second_tag, i_clk, i_rst_n, load, r_out_second == $past(r_phase))
    // history tracks the sample just produced
    `BRR_ASSERT_NXT(a_hist_mirror, i_clk, i_rst_n, load, r_prev1 == r_out_sample)
    // older history shifts from newer unless key-on cleared it
    `BRR_ASSERT_NXT(a_hist_shift, i_clk, i_rst_n, load && !clr_now, r_prev2 == $past(r_prev1))

endmodule
